// ===== hw/rtl/qvr_pkg.sv =====
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared constants and register codes for the quaternion vector rotator.
// ---------------------------------------------------------------------------
package qvr_pkg;

	localparam int QVR_DATA_WIDTH = 16;  // vector component width
	localparam int QVR_FRAC_BITS  = 14;  // quaternion fraction bits
	localparam int QVR_CFG_DATA_W = 16;  // configuration write data width
	localparam int QVR_CFG_ADDR_W = 8;   // configuration register index width
	localparam int QVR_NUM_COMP   = 3;   // vector components
	localparam int QVR_NUM_WGT    = 9;   // rotation weights, row-major 3x3
	localparam int QVR_PIPE_DEPTH = 4;   // register stages from input to output

	typedef enum logic [QVR_CFG_ADDR_W-1:0] {
		QVR_REG_QUAT_W = 8'd0,
		QVR_REG_QUAT_X = 8'd1,
		QVR_REG_QUAT_Y = 8'd2,
		QVR_REG_QUAT_Z = 8'd3
	} qvr_reg_t;

endpackage

// ===== hw/rtl/qvr_weights.sv =====
// ---------------------------------------------------------------------------
// qvr_weights
// Quaternion registers and the registered 3x3 weight matrix built from them.
// ---------------------------------------------------------------------------
module qvr_weights #(
	parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS,
	parameter int QW        = 16,
	parameter int WGT_W     = 2 * QW + 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [qvr_pkg::QVR_CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [qvr_pkg::QVR_CFG_DATA_W-1:0]     cfg_data,
	output logic signed [WGT_W-1:0]                wgt_q [qvr_pkg::QVR_NUM_WGT]
);

	localparam logic signed [QW-1:0] QUAT_ONE = QW'(1) << FRAC_BITS;
	localparam int PW = 2 * QW;

	logic signed [QW-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic signed [QW-1:0] cfg_val;
	logic signed [PW-1:0] p_wx, p_wy, p_wz, p_xx, p_xy, p_xz, p_yy, p_yz, p_zz;
	logic signed [WGT_W-1:0] wgt_d [qvr_pkg::QVR_NUM_WGT];

	// sign-extend the 16-bit write data to the register width
	assign cfg_val = QW'($signed(cfg_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q <= QUAT_ONE;
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (qvr_pkg::qvr_reg_t'(cfg_addr))
				qvr_pkg::QVR_REG_QUAT_W: quat_w_q <= cfg_val;
				qvr_pkg::QVR_REG_QUAT_X: quat_x_q <= cfg_val;
				qvr_pkg::QVR_REG_QUAT_Y: quat_y_q <= cfg_val;
				qvr_pkg::QVR_REG_QUAT_Z: quat_z_q <= cfg_val;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		p_wx = PW'(quat_w_q) * PW'(quat_x_q);
		p_wy = PW'(quat_w_q) * PW'(quat_y_q);
		p_wz = PW'(quat_w_q) * PW'(quat_z_q);
		p_xx = PW'(quat_x_q) * PW'(quat_x_q);
		p_xy = PW'(quat_x_q) * PW'(quat_y_q);
		p_xz = PW'(quat_x_q) * PW'(quat_z_q);
		p_yy = PW'(quat_y_q) * PW'(quat_y_q);
		p_yz = PW'(quat_y_q) * PW'(quat_z_q);
		p_zz = PW'(quat_z_q) * PW'(quat_z_q);

		wgt_d[0] = -WGT_W'(p_yy) - WGT_W'(p_zz);
		wgt_d[1] =  WGT_W'(p_xy) - WGT_W'(p_wz);
		wgt_d[2] =  WGT_W'(p_wy) + WGT_W'(p_xz);
		wgt_d[3] =  WGT_W'(p_wz) + WGT_W'(p_xy);
		wgt_d[4] = -WGT_W'(p_xx) - WGT_W'(p_zz);
		wgt_d[5] =  WGT_W'(p_yz) - WGT_W'(p_wx);
		wgt_d[6] =  WGT_W'(p_xz) - WGT_W'(p_wy);
		wgt_d[7] =  WGT_W'(p_wx) + WGT_W'(p_yz);
		wgt_d[8] = -WGT_W'(p_xx) - WGT_W'(p_yy);
	end

	// identity quaternion gives an all-zero weight matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qvr_pkg::QVR_NUM_WGT; i++) begin
				wgt_q[i] <= '0;
			end
		end else begin
			wgt_q <= wgt_d;
		end
	end

endmodule

// ===== hw/rtl/qvr_round_sat.sv =====
// ---------------------------------------------------------------------------
// qvr_round_sat
// Scale a biased dot product, add the input component and clip to range.
// ---------------------------------------------------------------------------
module qvr_round_sat #(
	parameter int DATA_WIDTH = qvr_pkg::QVR_DATA_WIDTH,
	parameter int FRAC_BITS  = qvr_pkg::QVR_FRAC_BITS,
	parameter int SUM_W      = 70
) (
	input  logic signed [SUM_W-1:0]      sum,
	input  logic signed [DATA_WIDTH-1:0] vec,
	output logic signed [DATA_WIDTH-1:0] rot,
	output logic                         sat
);

	localparam int SH  = 2 * FRAC_BITS - 1;
	localparam int T_W = SUM_W + 1;
	localparam logic signed [T_W-1:0] MAXV =
		{{(T_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [T_W-1:0] MINV = ~MAXV;

	logic signed [SUM_W-1:0] corr;
	logic signed [T_W-1:0]   total;

	always_comb begin
		// the rounding bias is already in sum, so floor gives round-half-up
		corr  = sum >>> SH;
		total = T_W'(corr) + T_W'(vec);
		if (total > MAXV) begin
			rot = DATA_WIDTH'(MAXV);
			sat = 1'b1;
		end else if (total < MINV) begin
			rot = DATA_WIDTH'(MINV);
			sat = 1'b1;
		end else begin
			rot = DATA_WIDTH'(total);
			sat = 1'b0;
		end
	end

endmodule

// ===== hw/rtl/quaternion_vector_rotate_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_vector_rotate_core
// An accepted request passes registers s1, s2, s3 and s4; s4 drives the master side.
// Throughput: one vector per cycle if m_tready is high (four-stage multiply/sum pipe).
// A configuration write loads a quaternion register; the weight matrix is registered from it.
// Reset: asynchronous, clears all stage valids and loads the identity quaternion.
// ---------------------------------------------------------------------------
module quaternion_vector_rotate_core #(
	parameter int DATA_WIDTH = qvr_pkg::QVR_DATA_WIDTH,
	parameter int FRAC_BITS  = qvr_pkg::QVR_FRAC_BITS,
	parameter int TDATA_W    = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave side: input vectors
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [TDATA_W-1:0]                 s_tdata,   // vec_x, vec_y, vec_z, zero pad
	// master side: rotated vectors
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [TDATA_W-1:0]                 m_tdata,   // rot_x, rot_y, rot_z, zero pad
	output logic [0:0]                         m_tuser,   // saturated
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [qvr_pkg::QVR_CFG_ADDR_W-1:0] cfg_addr,
	input  logic [qvr_pkg::QVR_CFG_DATA_W-1:0] cfg_data
);

	localparam int NC     = qvr_pkg::QVR_NUM_COMP;
	localparam int NW     = qvr_pkg::QVR_NUM_WGT;
	// quaternion registers widen so that 1.0 still fits at large FRAC_BITS
	localparam int QW     = (FRAC_BITS + 2 > qvr_pkg::QVR_CFG_DATA_W) ?
	                        FRAC_BITS + 2 : qvr_pkg::QVR_CFG_DATA_W;
	localparam int WGT_W  = 2 * QW + 1;
	localparam int PROD_W = WGT_W + DATA_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SH     = 2 * FRAC_BITS - 1;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (SH - 1);
	localparam int PAD_W  = TDATA_W - NC * DATA_WIDTH;

	// Configuration writes are always taken; the user keeps the core idle when they occur.
	assign cfg_ready = 1'b1;

	logic signed [WGT_W-1:0] wgt_q [NW];

	qvr_weights #(
		.FRAC_BITS (FRAC_BITS),
		.QW        (QW),
		.WGT_W     (WGT_W)
	) u_weights (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.wgt_q     (wgt_q)
	);

	// -------------------------------------------------------------------
	// Stage control: each stage advances when it is empty or the next one
	// advances, so bubbles collapse and the input keeps flowing into empty
	// stages while a finished result waits on the master side.
	// -------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// -------------------------------------------------------------------
	// Payload stages (no reset)
	// s1: capture the request; the weight matrix is settled by now
	// s2: nine weight x component products
	// s3: three row sums plus the rounding bias
	// s4: scale, add input, clip; this is the output register
	// -------------------------------------------------------------------
	logic signed [DATA_WIDTH-1:0] vec_s1 [NC];
	logic signed [DATA_WIDTH-1:0] vec_s2 [NC];
	logic signed [DATA_WIDTH-1:0] vec_s3 [NC];
	logic signed [PROD_W-1:0]     prod_s2 [NW];
	logic signed [SUM_W-1:0]      sum_s3 [NC];
	logic signed [DATA_WIDTH-1:0] rot_s4 [NC];
	logic                         sat_s4;

	logic signed [DATA_WIDTH-1:0] rot_d [NC];
	logic [NC-1:0]                sat_d;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int c = 0; c < NC; c++) begin
				vec_s1[c] <= s_tdata[c*DATA_WIDTH +: DATA_WIDTH];
			end
		end
		if (en_s2) begin
			vec_s2 <= vec_s1;
			for (int i = 0; i < NW; i++) begin
				prod_s2[i] <= PROD_W'(wgt_q[i]) * PROD_W'(vec_s1[i % NC]);
			end
		end
		if (en_s3) begin
			vec_s3 <= vec_s2;
			for (int r = 0; r < NC; r++) begin
				sum_s3[r] <= SUM_W'(prod_s2[r*NC]) + SUM_W'(prod_s2[r*NC + 1])
				           + SUM_W'(prod_s2[r*NC + 2]) + RND;
			end
		end
		if (en_s4) begin
			rot_s4 <= rot_d;
			sat_s4 <= |sat_d;
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_comp
		qvr_round_sat #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS),
			.SUM_W      (SUM_W)
		) u_round_sat (
			.sum (sum_s3[g]),
			.vec (vec_s3[g]),
			.rot (rot_d[g]),
			.sat (sat_d[g])
		);
	end

	// Drive the master side straight from the output register.
	assign m_tvalid = v_s4;
	assign m_tuser  = sat_s4;
	always_comb begin
		m_tdata = '0;
		for (int c = 0; c < NC; c++) begin
			m_tdata[c*DATA_WIDTH +: DATA_WIDTH] = rot_s4[c];
		end
		if (PAD_W > 0) begin
			m_tdata[TDATA_W-1 -: ((PAD_W > 0) ? PAD_W : 1)] = '0;
		end
	end

endmodule

// ===== hw/rtl/qvr_checker.sv =====
// ---------------------------------------------------------------------------
// qvr_checker
// Port-level checks for the quaternion vector rotator, bound to the top.
// ---------------------------------------------------------------------------
module qvr_checker #(
	parameter int DATA_WIDTH = qvr_pkg::QVR_DATA_WIDTH,
	parameter int TDATA_W    = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [0:0]         m_tuser
);

	localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MINV = ~MAXV;

	logic [3:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// No result without an outstanding request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 4'd0)
		else $error("result without request");

	// Requests in flight never exceed the pipeline depth.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'(qvr_pkg::QVR_PIPE_DEPTH))
		else $error("too many requests in flight");

	// An empty output register never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// The saturation flag implies a component at a rail.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[DATA_WIDTH-1:0] == MAXV || m_tdata[DATA_WIDTH-1:0] == MINV ||
			m_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == MAXV ||
			m_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == MINV ||
			m_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH] == MAXV ||
			m_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH] == MINV)
		else $error("saturation flag without clipped component");

endmodule

bind quaternion_vector_rotate_core qvr_checker #(
	.DATA_WIDTH (DATA_WIDTH),
	.TDATA_W    (TDATA_W)
) u_qvr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
